/* design/ilb_pkg.sv */
package ilb_pkg;

    localparam int DEPTH = 64;
    localparam int WIDTH = 32;
    localparam int CNT_W = 7;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] MIN_CAP = CNT_W'(4);

    typedef enum logic [2:0] {
        FUNC_APPEND = 3'd0,
        FUNC_INSERT = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_READ   = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [2:0]              func;
        logic [CNT_W-1:0]        position;
        logic signed [WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [WIDTH-1:0] read_value;
        logic [CNT_W-1:0]        count;
        logic [CNT_W-1:0]        capacity_now;
    } rsp_t;

    typedef struct packed {
        cell_op_t                op;
        logic [CNT_W-1:0]        position;
        logic signed [WIDTH-1:0] value;
    } cell_ctrl_t;

endpackage

/* design/ilb_cell.sv */
module ilb_cell (
    input  logic                              clk,
    input  logic [ilb_pkg::CNT_W-1:0]         cell_index,
    input  ilb_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ilb_pkg::WIDTH-1:0]  lower_word,
    input  logic signed [ilb_pkg::WIDTH-1:0]  upper_word,
    output logic signed [ilb_pkg::WIDTH-1:0]  word,
    output logic signed [ilb_pkg::WIDTH-1:0]  read_word
);

    logic signed [ilb_pkg::WIDTH-1:0] word_reg;
    logic signed [ilb_pkg::WIDTH-1:0] word_next;
    logic                             hit;

    assign hit = (cell_index == ctrl.position);

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            ilb_pkg::CELL_INSERT:
            begin
                if (hit)
                begin
                    word_next = ctrl.value;
                end
                else if (cell_index > ctrl.position)
                begin
                    word_next = lower_word;
                end
            end
            ilb_pkg::CELL_REMOVE:
            begin
                if (cell_index >= ctrl.position)
                begin
                    word_next = upper_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    // Only the addressed cell contributes to the read bus, so the top can OR all cells.
    assign read_word = hit ? word_reg : '0;

endmodule

/* design/ilb_ctrl.sv */
module ilb_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  ilb_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output ilb_pkg::rsp_t                     rsp,
    input  logic signed [ilb_pkg::WIDTH-1:0]  read_bus,
    output ilb_pkg::cell_ctrl_t               cell_ctrl
);

    logic [ilb_pkg::CNT_W-1:0] count_reg;
    logic [ilb_pkg::CNT_W-1:0] count_next;
    logic [ilb_pkg::CNT_W-1:0] cap_reg;
    logic [ilb_pkg::CNT_W-1:0] cap_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    ilb_pkg::rsp_t             rsp_reg;
    ilb_pkg::rsp_t             rsp_next;

    logic                      accept;
    logic [ilb_pkg::CNT_W:0]   cap_double;
    logic [ilb_pkg::CNT_W-1:0] cap_grown;
    logic [ilb_pkg::CNT_W-1:0] cap_half;
    logic [ilb_pkg::CNT_W-1:0] count_dec;
    logic                      store_full;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept = req_valid && req_ready;
    assign store_full = (count_reg >= ilb_pkg::DEPTH_CNT);
    assign count_dec = count_reg - ilb_pkg::CNT_W'(1);

    // Capacity doubles only when the list has reached it, saturating at the store depth.
    always_comb
    begin
        cap_double = {1'b0, cap_reg} << 1;
        if (count_reg < cap_reg)
        begin
            cap_grown = cap_reg;
        end
        else if (cap_double > {1'b0, ilb_pkg::DEPTH_CNT})
        begin
            cap_grown = ilb_pkg::DEPTH_CNT;
        end
        else
        begin
            cap_grown = cap_double[ilb_pkg::CNT_W-1:0];
        end
        cap_half = cap_reg >> 1;
        if (cap_half < ilb_pkg::MIN_CAP)
        begin
            cap_half = ilb_pkg::MIN_CAP;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        cap_next = cap_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cell_ctrl.op = ilb_pkg::CELL_HOLD;
        cell_ctrl.position = req.position;
        cell_ctrl.value = req.value;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.status = ilb_pkg::STAT_OK;
            rsp_next.read_value = '0;
            case (req.func)
                ilb_pkg::FUNC_APPEND:
                begin
                    if (store_full)
                    begin
                        rsp_next.status = ilb_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cell_ctrl.op = ilb_pkg::CELL_INSERT;
                        cell_ctrl.position = count_reg;
                        cap_next = cap_grown;
                        count_next = count_reg + ilb_pkg::CNT_W'(1);
                    end
                end
                ilb_pkg::FUNC_INSERT:
                begin
                    if (req.position > count_reg)
                    begin
                        rsp_next.status = ilb_pkg::STAT_RANGE;
                    end
                    else if (store_full)
                    begin
                        rsp_next.status = ilb_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cell_ctrl.op = ilb_pkg::CELL_INSERT;
                        cap_next = cap_grown;
                        count_next = count_reg + ilb_pkg::CNT_W'(1);
                    end
                end
                ilb_pkg::FUNC_REMOVE:
                begin
                    if (req.position >= count_reg)
                    begin
                        rsp_next.status = ilb_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        cell_ctrl.op = ilb_pkg::CELL_REMOVE;
                        count_next = count_dec;
                        if ((count_dec <= (cap_reg >> 2)) && (cap_reg > ilb_pkg::MIN_CAP))
                        begin
                            cap_next = cap_half;
                        end
                    end
                end
                ilb_pkg::FUNC_READ:
                begin
                    if (req.position >= count_reg)
                    begin
                        rsp_next.status = ilb_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        rsp_next.read_value = read_bus;
                    end
                end
                ilb_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                    cap_next = ilb_pkg::MIN_CAP;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            rsp_next.count = count_next;
            rsp_next.capacity_now = cap_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg <= ilb_pkg::MIN_CAP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            cap_reg <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

/* design/indexed_list_buffer.sv */
// Ordered list of signed 32-bit words held in a row of 64 storage cells.
// Requests arrive on req (req_valid/req_ready) carrying func, position and
// value; one response per request leaves on rsp (rsp_valid/rsp_ready) with
// status, read_value, count and capacity_now after the operation.
// Insert and remove move every later word one cell up or down at once, each
// cell taking its neighbor's word. The response is registered: it appears
// in the cycle after the request is accepted, and a new request is accepted
// every cycle while rsp is taken.
// A stalled receiver holds the response register; req_ready stays high only
// while that register is empty or being emptied in the same cycle, so at most
// one response waits and no request is lost.
// Reset clears the count to 0 and the capacity to 4 at once. The cell
// contents are not cleared; words at or beyond the count are unreachable,
// so no clearing pass is needed and requests are accepted right after reset.
module indexed_list_buffer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ilb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ilb_pkg::rsp_t rsp
);

    ilb_pkg::cell_ctrl_t              cell_ctrl;
    logic signed [ilb_pkg::WIDTH-1:0] words [ilb_pkg::DEPTH];
    logic signed [ilb_pkg::WIDTH-1:0] read_words [ilb_pkg::DEPTH];
    logic signed [ilb_pkg::WIDTH-1:0] read_bus;

    ilb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .read_bus  (read_bus),
        .cell_ctrl (cell_ctrl)
    );

    for (genvar k = 0; k < ilb_pkg::DEPTH; k++)
    begin : g_cell
        logic signed [ilb_pkg::WIDTH-1:0] lower_word;
        logic signed [ilb_pkg::WIDTH-1:0] upper_word;

        if (k == 0)
        begin : g_bottom
            assign lower_word = '0;
        end
        else
        begin : g_lower
            assign lower_word = words[k-1];
        end

        if (k == ilb_pkg::DEPTH - 1)
        begin : g_top
            assign upper_word = words[k];
        end
        else
        begin : g_upper
            assign upper_word = words[k+1];
        end

        ilb_cell u_cell (
            .clk        (clk),
            .cell_index (ilb_pkg::CNT_W'(k)),
            .ctrl       (cell_ctrl),
            .lower_word (lower_word),
            .upper_word (upper_word),
            .word       (words[k]),
            .read_word  (read_words[k])
        );
    end

    always_comb
    begin
        read_bus = '0;
        for (int k = 0; k < ilb_pkg::DEPTH; k++)
        begin
            read_bus = read_bus | read_words[k];
        end
    end

endmodule

/* sim/indexed_list_buffer_tb.sv */
module indexed_list_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_MID   = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
    localparam int POS_MAX = (1 << ilb_pkg::CNT_W) - 1;
    localparam int MIN_CAP_INT = int'(ilb_pkg::MIN_CAP);

    localparam int MODE_GROW   = 0;
    localparam int MODE_MIXED  = 1;
    localparam int MODE_SHRINK = 2;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    ilb_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    ilb_pkg::rsp_t rsp;

    // List state as the block should hold it.
    logic signed [ilb_pkg::WIDTH-1:0] list_words [ilb_pkg::DEPTH];
    int list_len = 0;
    int list_cap = MIN_CAP_INT;

    ilb_pkg::req_t pending_reqs [$];
    ilb_pkg::rsp_t expected_rsps [$];
    ilb_pkg::rsp_t want;

    int plan_len = 0;
    int sent_count = 0;
    int rsp_count = 0;
    int mismatches = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    int seen_ok = 0;
    int seen_range = 0;
    int seen_full = 0;
    int peak_len = 0;
    int peak_cap = 0;

    indexed_list_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    function automatic void widen_capacity();
        if (list_len >= list_cap)
            list_cap = (list_cap * 2 > ilb_pkg::DEPTH) ? ilb_pkg::DEPTH : list_cap * 2;
    endfunction

    function automatic ilb_pkg::rsp_t apply_request(ilb_pkg::req_t r);
        ilb_pkg::rsp_t o;
        int i;
        int pos;
        o = '0;
        o.status = ilb_pkg::STAT_OK;
        pos = int'(r.position);
        case (r.func)
            ilb_pkg::FUNC_APPEND:
                if (list_len >= ilb_pkg::DEPTH)
                    o.status = ilb_pkg::STAT_FULL;
                else
                begin
                    widen_capacity();
                    list_words[list_len] = r.value;
                    list_len++;
                end
            ilb_pkg::FUNC_INSERT:
                // The index is tested before the store is found full.
                if (pos > list_len)
                    o.status = ilb_pkg::STAT_RANGE;
                else if (list_len >= ilb_pkg::DEPTH)
                    o.status = ilb_pkg::STAT_FULL;
                else
                begin
                    widen_capacity();
                    for (i = list_len; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = r.value;
                    list_len++;
                end
            ilb_pkg::FUNC_REMOVE:
                if (pos >= list_len)
                    o.status = ilb_pkg::STAT_RANGE;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    if (list_len <= list_cap / 4 && list_cap > MIN_CAP_INT)
                        list_cap = (list_cap / 2 < MIN_CAP_INT) ? MIN_CAP_INT : list_cap / 2;
                end
            ilb_pkg::FUNC_READ:
                if (pos >= list_len)
                    o.status = ilb_pkg::STAT_RANGE;
                else
                    o.read_value = list_words[pos];
            ilb_pkg::FUNC_CLEAR:
            begin
                list_len = 0;
                list_cap = MIN_CAP_INT;
            end
            default:
                ;
        endcase
        o.count = ilb_pkg::CNT_W'(list_len);
        o.capacity_now = ilb_pkg::CNT_W'(list_cap);
        return o;
    endfunction

    // Queues one request and keeps a running length so that later positions
    // can be aimed at the list as it will be.
    task automatic plan_request(logic [2:0] f, int pos, logic [ilb_pkg::WIDTH-1:0] v);
        ilb_pkg::req_t r;
        r.func = f;
        r.position = ilb_pkg::CNT_W'(pos);
        r.value = v;
        pending_reqs.push_back(r);
        case (f)
            ilb_pkg::FUNC_APPEND: if (plan_len < ilb_pkg::DEPTH) plan_len++;
            ilb_pkg::FUNC_INSERT: if (pos <= plan_len && plan_len < ilb_pkg::DEPTH) plan_len++;
            ilb_pkg::FUNC_REMOVE: if (pos < plan_len) plan_len--;
            ilb_pkg::FUNC_CLEAR:  plan_len = 0;
            default:              ;
        endcase
    endtask

    function automatic int pick_position(int limit);
        int roll;
        roll = $urandom_range(99);
        if (limit < 0)
            limit = 0;
        if (roll < 10)
            return 0;
        else if (roll < 20)
            return limit;
        else if (roll < 85)
            return $urandom_range(limit, 0);
        else
            return $urandom_range(POS_MAX, 0);
    endfunction

    function automatic logic [ilb_pkg::WIDTH-1:0] pick_value();
        case ($urandom_range(39))
            0:       return {1'b0, {(ilb_pkg::WIDTH-1){1'b1}}};
            1:       return {1'b1, {(ilb_pkg::WIDTH-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic plan_burst(int mode, int n);
        int k;
        int roll;
        int t_app;
        int t_ins;
        int t_rem;
        int t_rd;
        int t_unused;
        case (mode)
            MODE_GROW:
            begin
                t_app = 45; t_ins = 80; t_rem = 88; t_rd = 96; t_unused = 100;
            end
            MODE_SHRINK:
            begin
                t_app = 5;  t_ins = 10; t_rem = 75; t_rd = 95; t_unused = 99;
            end
            default:
            begin
                t_app = 20; t_ins = 40; t_rem = 65; t_rd = 90; t_unused = 95;
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (roll < t_app)
                plan_request(ilb_pkg::FUNC_APPEND, $urandom_range(POS_MAX, 0), pick_value());
            else if (roll < t_ins)
                plan_request(ilb_pkg::FUNC_INSERT, pick_position(plan_len), pick_value());
            else if (roll < t_rem)
                plan_request(ilb_pkg::FUNC_REMOVE, pick_position(plan_len - 1), pick_value());
            else if (roll < t_rd)
                plan_request(ilb_pkg::FUNC_READ, pick_position(plan_len - 1), pick_value());
            else if (roll < t_unused)
                plan_request(3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST)),
                             $urandom_range(POS_MAX, 0), pick_value());
            else
                plan_request(ilb_pkg::FUNC_CLEAR, $urandom_range(POS_MAX, 0), pick_value());
        end
    endtask

    task automatic wait_drained();
        while (!(pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0))
            @(posedge clk);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(apply_request(req));
                sent_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 &&
                    ((sent_count >= 450 && sent_count < 550) || $urandom_range(99) >= 35))
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor and receiver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response: status %0d value %0d count %0d cap %0d",
                                 $time, rsp.status, rsp.read_value, rsp.count,
                                 rsp.capacity_now);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
                        rsp.count !== want.count || rsp.capacity_now !== want.capacity_now)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: response %0d: expected status %0d value %0d",
                                     $time, rsp_count, want.status, want.read_value);
                            $display("    count %0d capacity %0d, got status %0d value %0d",
                                     want.count, want.capacity_now, rsp.status,
                                     rsp.read_value);
                            $display("    count %0d capacity %0d",
                                     rsp.count, rsp.capacity_now);
                        end
                    end
                end
                case (rsp.status)
                    ilb_pkg::STAT_OK:    seen_ok++;
                    ilb_pkg::STAT_RANGE: seen_range++;
                    ilb_pkg::STAT_FULL:  seen_full++;
                    default:             ;
                endcase
                if (int'(rsp.count) > peak_len)
                    peak_len = int'(rsp.count);
                if (int'(rsp.capacity_now) > peak_cap)
                    peak_cap = int'(rsp.capacity_now);
            end

            // One long hold-off lets the block back up and stall its input.
            if (!stall_done && rsp_count == 200)
            begin
                stall_done = 1'b1;
                stall_left = 60;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (rsp_count >= 450 && rsp_count < 550)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 35);
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        // Empty list: every indexed access is out of range.
        plan_request(ilb_pkg::FUNC_READ, 0, '0);
        plan_request(ilb_pkg::FUNC_REMOVE, 0, '1);
        plan_request(ilb_pkg::FUNC_INSERT, 1, 32'h1234_5678);
        plan_request(ilb_pkg::FUNC_APPEND, POS_MAX, 32'h7FFF_FFFF);
        plan_request(ilb_pkg::FUNC_APPEND, 0, 32'h8000_0000);
        plan_request(ilb_pkg::FUNC_INSERT, 0, 32'hFFFF_FFFF);
        plan_request(ilb_pkg::FUNC_INSERT, 3, 32'h0000_0000);
        plan_request(ilb_pkg::FUNC_INSERT, 2, 32'h0000_0005);
        plan_request(ilb_pkg::FUNC_INSERT, 6, 32'h5555_AAAA);
        plan_request(ilb_pkg::FUNC_READ, 0, '0);
        plan_request(ilb_pkg::FUNC_READ, 4, '0);
        plan_request(ilb_pkg::FUNC_READ, 5, '0);
        plan_request(ilb_pkg::FUNC_READ, POS_MAX, '1);
        plan_request(ilb_pkg::FUNC_REMOVE, 2, '0);
        plan_request(ilb_pkg::FUNC_REMOVE, 0, '0);
        plan_request(ilb_pkg::FUNC_REMOVE, 2, '0);
        plan_request(ilb_pkg::FUNC_REMOVE, POS_MAX, '0);
        plan_request(FUNC_UNUSED_FIRST, 0, 32'hAAAA_5555);
        plan_request(FUNC_UNUSED_MID, 64, '1);
        plan_request(FUNC_UNUSED_LAST, POS_MAX, '0);
        plan_request(ilb_pkg::FUNC_READ, 1, '0);
        plan_request(ilb_pkg::FUNC_CLEAR, POS_MAX, '1);
        plan_request(ilb_pkg::FUNC_READ, 0, '0);
        wait_drained();

        // Fill to the top of the store, then drain back down.
        plan_burst(MODE_GROW, 80);
        plan_burst(MODE_GROW, 80);
        plan_burst(MODE_MIXED, 80);
        plan_burst(MODE_SHRINK, 80);
        wait_drained();

        plan_burst(MODE_SHRINK, 80);
        plan_burst(MODE_GROW, 80);
        plan_burst(MODE_MIXED, 80);
        plan_burst(MODE_SHRINK, 80);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Ran %0d requests: %0d ok, %0d out of range, %0d refused as full.",
                 sent_count, seen_ok, seen_range, seen_full);
        $display("Longest list %0d words, largest capacity %0d, %0d mismatches.",
                 peak_len, peak_cap, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Timed out with %0d responses still expected.", expected_rsps.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
